@@ src/ljpf_pkg.sv @@
// Shared types, constants and arithmetic helpers for the Lennard-Jones pair force accumulator.
// No dependencies; used by every other file of the block.
package ljpf_pkg;

   localparam int MAX_PARTICLES_DEF = 64;

   localparam int POS_W  = 24;
   localparam int CUT_W  = 26;
   localparam int CSR_W  = 26;
   localparam int FRC_W  = 32;
   localparam int PID_W  = 6;
   localparam int DEL_W  = 26;  // signed minimum-image delta
   localparam int DMAG_W = 25;  // delta magnitude
   localparam int R2_W   = 50;  // r squared, Q.40
   localparam int DIV_QW = 24;  // 1/r^2 quotient, Q.22
   localparam int DIV_CW = 5;
   localparam int FMAG_W = 35;
   localparam int PROD_W = 64;
   localparam int LO_W   = 57;
   localparam int FULL_W = 61;

   localparam logic [POS_W-1:0]  BOX_RESET = 24'd6291456;
   localparam logic [CUT_W-1:0]  CUT_RESET = 26'd6553600;
   localparam logic [R2_W-1:0]   R2_NEAR   = 50'h1 << 38;  // at or below: quotient saturates
   localparam logic [R2_W-1:0]   DIV_INIT  = 50'h1 << 38;  // 2^62 shifted down by DIV_QW
   localparam logic [FMAG_W-1:0] FACTOR_CAP = {FMAG_W{1'b1}};

   typedef enum logic [0:0] {
      CSR_BOX_LENGTH = 1'b0,
      CSR_CUTOFF_SQ  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [PID_W-1:0]        particle;
      logic signed [FRC_W-1:0] force_x;
      logic signed [FRC_W-1:0] force_y;
      logic signed [FRC_W-1:0] force_z;
      logic                    overflow;
      logic                    final_res;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROW_RD, ST_ROW_LD, ST_PAIR_RD, ST_PAIR_LD, ST_MUL, ST_USE, ST_CMP,
      ST_DIV, ST_FAC, ST_UPD, ST_NEXT, ST_ROW_END, ST_OUT_RD, ST_OUT_EM
   } state_type;

   typedef enum logic [3:0] {
      OP_SQX, OP_SQY, OP_SQZ, OP_S2, OP_S3, OP_S4, OP_S7,
      OP_CXL, OP_CXH, OP_CYL, OP_CYH, OP_CZL, OP_CZH
   } op_type;

   // Minimum-image delta a-b with a single conditional wrap.
   function automatic logic signed [DEL_W-1:0] delta(logic [POS_W-1:0] a,
                                                     logic [POS_W-1:0] b,
                                                     logic [POS_W-1:0] len);
      logic signed [DEL_W-1:0] d;
      logic signed [DEL_W:0]   d2;
      logic signed [DEL_W:0]   l;
      d  = $signed({2'b00, a}) - $signed({2'b00, b});
      d2 = {d, 1'b0};
      l  = $signed({3'b000, len});
      if (d2 > l) begin
         delta = d - $signed({2'b00, len});
      end else if (d2 < -l) begin
         delta = d + $signed({2'b00, len});
      end else begin
         delta = d;
      end
   endfunction

   function automatic logic signed [FRC_W-1:0] sat32(logic signed [FRC_W:0] v);
      if (v > $signed({2'b00, {(FRC_W-1){1'b1}}})) begin
         sat32 = {1'b0, {(FRC_W-1){1'b1}}};
      end else if (v < $signed({2'b11, {(FRC_W-1){1'b0}}})) begin
         sat32 = {1'b1, {(FRC_W-1){1'b0}}};
      end else begin
         sat32 = v[FRC_W-1:0];
      end
   endfunction

   // Drop 20 fraction bits of |factor|*|delta|, clamp and apply the sign.
   function automatic logic signed [FRC_W-1:0] contrib(logic [FULL_W-1:0] full, logic neg);
      logic [FULL_W-21:0] m;
      m = full[FULL_W-1:20];
      if (neg) begin
         if (m > 41'h0_8000_0000) m = 41'h0_8000_0000;
         contrib = FRC_W'(41'd0 - m);
      end else begin
         if (m > 41'h0_7FFF_FFFF) m = 41'h0_7FFF_FFFF;
         contrib = FRC_W'(m);
      end
   endfunction

endpackage

@@ src/ljpf_div.sv @@
// Restoring divider forming floor(2^62 / r2), one quotient bit per cycle.
// Depends on ljpf_pkg. Divisor must exceed 2^38 so the quotient fits in 24 bits.
module ljpf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ljpf_pkg::R2_W-1:0]    divisor,
   output logic                         done,
   output logic [ljpf_pkg::DIV_QW-1:0]  quotient
);
   logic [ljpf_pkg::R2_W-1:0]   rem_ff, rem_in;
   logic [ljpf_pkg::DIV_QW-1:0] q_ff, q_in;
   logic [ljpf_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [ljpf_pkg::R2_W:0]     trial;
   logic                        ge;

   assign trial = {rem_ff, 1'b0};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = ljpf_pkg::DIV_INIT;
         q_in   = '0;
         cnt_in = ljpf_pkg::DIV_CW'(ljpf_pkg::DIV_QW - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? ljpf_pkg::R2_W'(trial - {1'b0, divisor}) : trial[ljpf_pkg::R2_W-1:0];
         q_in   = {q_ff[ljpf_pkg::DIV_QW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

@@ src/lj_pair_force_accumulator.sv @@
// Items load while the block is idle; the item marked last starts the pair walk, or the
// results directly when fewer than two particles are loaded. Each pair i<j forms r^2 and
// stops outside the cutoff; too close for the divider it takes a saturated factor, else
// the 24-step divider runs. All products use the single shared 32x32 multiplier.
// Results then follow, never back to back, one per loaded particle; the receiver cannot stall.
// Synchronous active-high reset clears the control state and restores both registers.
module lj_pair_force_accumulator #(
   parameter int MAX_PARTICLES = ljpf_pkg::MAX_PARTICLES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  ljpf_pkg::req_type          req_data,
   output logic                       rsp_valid,
   output ljpf_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_addr,
   input  logic [ljpf_pkg::CSR_W-1:0] csr_wdata
);
   localparam int IW = $clog2(MAX_PARTICLES);
   localparam int CW = $clog2(MAX_PARTICLES + 1);
   localparam int PW = ljpf_pkg::POS_W;
   localparam int FW = ljpf_pkg::FRC_W;

   ljpf_pkg::state_type state_ff, state_in;
   ljpf_pkg::op_type    op_ff;

   logic [PW-1:0]                 box_ff;
   logic [ljpf_pkg::CUT_W-1:0]    cut_ff;
   logic [CW-1:0]                 count_ff, n_ff;
   logic                          dropped_ff;
   logic [IW-1:0]                 i_ff, j_ff, k_ff;

   logic [PW-1:0] sx_mem [MAX_PARTICLES];
   logic [PW-1:0] sy_mem [MAX_PARTICLES];
   logic [PW-1:0] sz_mem [MAX_PARTICLES];
   logic [FW-1:0] ax_mem [MAX_PARTICLES];
   logic [FW-1:0] ay_mem [MAX_PARTICLES];
   logic [FW-1:0] az_mem [MAX_PARTICLES];
   logic [MAX_PARTICLES-1:0] vld_ff;

   logic [PW-1:0] sx_rd_ff, sy_rd_ff, sz_rd_ff;
   logic [FW-1:0] ax_rd_ff, ay_rd_ff, az_rd_ff;
   logic          av_rd_ff;
   logic [PW-1:0] pi_ff [3];
   logic signed [FW-1:0] ai_ff [3];
   logic signed [FW-1:0] aj_ff [3];
   logic signed [FW-1:0] c_ff  [3];
   logic [ljpf_pkg::DMAG_W-1:0] dm_ff [3];
   logic          dn_ff [3];

   logic [ljpf_pkg::R2_W-1:0]   r2_ff;
   logic [ljpf_pkg::DIV_QW-1:0] s_ff;
   logic [25:0] s2_ff;
   logic [27:0] s3_ff;
   logic [29:0] s4_ff;
   logic [35:0] s7_ff;
   logic [ljpf_pkg::FMAG_W-1:0] fmag_ff, fmag_in;
   logic                        fneg_ff, fneg_in;
   logic [ljpf_pkg::PROD_W-1:0] mul_p_ff;
   logic [ljpf_pkg::LO_W-1:0]   lo_ff;

   // control outputs of the sequencer
   logic          accept, load_we, acc_we;
   logic [IW-1:0] ra, wa;
   logic [FW-1:0] wx, wy, wz;
   logic [31:0]   mul_a, mul_b;
   logic          div_start, div_done;
   logic [ljpf_pkg::DIV_QW-1:0] div_q;
   logic          in_cut, near;
   logic [CW-1:0] count_nx;

   logic signed [ljpf_pkg::DEL_W-1:0] d_w [3];
   logic signed [FW-1:0] aj_new [3];
   logic [41:0] f48, f24, fdif;
   logic        fpos;
   logic [ljpf_pkg::FULL_W-1:0] full;

   assign accept   = start && !busy;
   assign count_nx = (count_ff < CW'(MAX_PARTICLES)) ? count_ff + 1'b1 : count_ff;
   assign in_cut   = r2_ff < {4'b0000, cut_ff, 20'b0};
   assign near     = r2_ff <= ljpf_pkg::R2_NEAR;
   assign full     = ljpf_pkg::FULL_W'(lo_ff) + {mul_p_ff[28:0], 32'b0};

   assign d_w[0] = ljpf_pkg::delta(pi_ff[0], sx_rd_ff, box_ff);
   assign d_w[1] = ljpf_pkg::delta(pi_ff[1], sy_rd_ff, box_ff);
   assign d_w[2] = ljpf_pkg::delta(pi_ff[2], sz_rd_ff, box_ff);

   // factor = 48*s7 - 24*s4, to Q.16 toward zero, clamped
   assign f48  = {1'b0, s7_ff, 5'b0} + {2'b00, s7_ff, 4'b0};
   assign f24  = {8'b0, s4_ff, 4'b0} + {9'b0, s4_ff, 3'b0};
   assign fpos = f48 >= f24;
   assign fdif = fpos ? f48 - f24 : f24 - f48;
   always_comb begin
      fmag_in = (fdif[41:6] > {1'b0, ljpf_pkg::FACTOR_CAP}) ? ljpf_pkg::FACTOR_CAP
                                                          : fdif[40:6];
      fneg_in = !fpos;
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         aj_new[a] = ljpf_pkg::sat32({aj_ff[a][FW-1], aj_ff[a]} - {c_ff[a][FW-1], c_ff[a]});
      end
   end

   ljpf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (r2_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ljpf_pkg::ST_IDLE: begin
            if (accept && req_data.last) begin
               state_in = (count_nx >= CW'(2)) ? ljpf_pkg::ST_ROW_RD : ljpf_pkg::ST_OUT_RD;
            end
         end
         ljpf_pkg::ST_ROW_RD:  state_in = ljpf_pkg::ST_ROW_LD;
         ljpf_pkg::ST_ROW_LD:  state_in = ljpf_pkg::ST_PAIR_RD;
         ljpf_pkg::ST_PAIR_RD: state_in = ljpf_pkg::ST_PAIR_LD;
         ljpf_pkg::ST_PAIR_LD: state_in = ljpf_pkg::ST_MUL;
         ljpf_pkg::ST_MUL:     state_in = ljpf_pkg::ST_USE;
         ljpf_pkg::ST_USE: begin
            case (op_ff)
               ljpf_pkg::OP_SQZ: state_in = ljpf_pkg::ST_CMP;
               ljpf_pkg::OP_S7:  state_in = ljpf_pkg::ST_FAC;
               ljpf_pkg::OP_CZH: state_in = ljpf_pkg::ST_UPD;
               default:          state_in = ljpf_pkg::ST_MUL;
            endcase
         end
         ljpf_pkg::ST_CMP: begin
            if (!in_cut)   state_in = ljpf_pkg::ST_NEXT;
            else if (near) state_in = ljpf_pkg::ST_MUL;
            else           state_in = ljpf_pkg::ST_DIV;
         end
         ljpf_pkg::ST_DIV:     if (div_done) state_in = ljpf_pkg::ST_MUL;
         ljpf_pkg::ST_FAC:     state_in = ljpf_pkg::ST_MUL;
         ljpf_pkg::ST_UPD:     state_in = ljpf_pkg::ST_NEXT;
         ljpf_pkg::ST_NEXT: begin
            state_in = (CW'(j_ff) + 1'b1 < n_ff) ? ljpf_pkg::ST_PAIR_RD : ljpf_pkg::ST_ROW_END;
         end
         ljpf_pkg::ST_ROW_END: begin
            state_in = (CW'(i_ff) + CW'(2) < n_ff) ? ljpf_pkg::ST_ROW_RD : ljpf_pkg::ST_OUT_RD;
         end
         ljpf_pkg::ST_OUT_RD:  state_in = ljpf_pkg::ST_OUT_EM;
         ljpf_pkg::ST_OUT_EM: begin
            state_in = (CW'(k_ff) + 1'b1 < n_ff) ? ljpf_pkg::ST_OUT_RD : ljpf_pkg::ST_IDLE;
         end
         default: state_in = ljpf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy      = state_ff != ljpf_pkg::ST_IDLE;
      rsp_valid = state_ff == ljpf_pkg::ST_OUT_EM;
      load_we   = accept && (count_ff < CW'(MAX_PARTICLES));
      div_start = (state_ff == ljpf_pkg::ST_CMP) && in_cut && !near;
      acc_we    = 1'b0;
      ra        = k_ff;
      wa        = i_ff;
      wx        = ai_ff[0];
      wy        = ai_ff[1];
      wz        = ai_ff[2];
      case (state_ff)
         ljpf_pkg::ST_ROW_RD:  ra = i_ff;
         ljpf_pkg::ST_PAIR_RD: ra = j_ff;
         ljpf_pkg::ST_UPD: begin
            acc_we = 1'b1;
            wa     = j_ff;
            wx     = aj_new[0];
            wy     = aj_new[1];
            wz     = aj_new[2];
         end
         ljpf_pkg::ST_ROW_END: acc_we = 1'b1;
         default: ra = k_ff;
      endcase
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         ljpf_pkg::OP_SQX: begin mul_a = 32'(dm_ff[0]); mul_b = 32'(dm_ff[0]); end
         ljpf_pkg::OP_SQY: begin mul_a = 32'(dm_ff[1]); mul_b = 32'(dm_ff[1]); end
         ljpf_pkg::OP_SQZ: begin mul_a = 32'(dm_ff[2]); mul_b = 32'(dm_ff[2]); end
         ljpf_pkg::OP_S2:  begin mul_a = 32'(s_ff);  mul_b = 32'(s_ff);  end
         ljpf_pkg::OP_S3:  begin mul_a = 32'(s2_ff); mul_b = 32'(s_ff);  end
         ljpf_pkg::OP_S4:  begin mul_a = 32'(s2_ff); mul_b = 32'(s2_ff); end
         ljpf_pkg::OP_S7:  begin mul_a = 32'(s4_ff); mul_b = 32'(s3_ff); end
         ljpf_pkg::OP_CXL: begin mul_a = fmag_ff[31:0];       mul_b = 32'(dm_ff[0]); end
         ljpf_pkg::OP_CXH: begin mul_a = 32'(fmag_ff[34:32]); mul_b = 32'(dm_ff[0]); end
         ljpf_pkg::OP_CYL: begin mul_a = fmag_ff[31:0];       mul_b = 32'(dm_ff[1]); end
         ljpf_pkg::OP_CYH: begin mul_a = 32'(fmag_ff[34:32]); mul_b = 32'(dm_ff[1]); end
         ljpf_pkg::OP_CZL: begin mul_a = fmag_ff[31:0];       mul_b = 32'(dm_ff[2]); end
         ljpf_pkg::OP_CZH: begin mul_a = 32'(fmag_ff[34:32]); mul_b = 32'(dm_ff[2]); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // position and accumulator stores
   always_ff @(posedge clock) begin
      if (load_we) begin
         sx_mem[count_ff[IW-1:0]] <= req_data.pos_x;
         sy_mem[count_ff[IW-1:0]] <= req_data.pos_y;
         sz_mem[count_ff[IW-1:0]] <= req_data.pos_z;
      end
      sx_rd_ff <= sx_mem[ra];
      sy_rd_ff <= sy_mem[ra];
      sz_rd_ff <= sz_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         ax_mem[wa] <= wx;
         ay_mem[wa] <= wy;
         az_mem[wa] <= wz;
      end
      ax_rd_ff <= ax_mem[ra];
      ay_rd_ff <= ay_mem[ra];
      az_rd_ff <= az_mem[ra];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ljpf_pkg::ST_IDLE;
         box_ff     <= ljpf_pkg::BOX_RESET;
         cut_ff     <= ljpf_pkg::CUT_RESET;
         count_ff   <= '0;
         n_ff       <= '0;
         dropped_ff <= 1'b0;
         vld_ff     <= '0;
         av_rd_ff   <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         op_ff      <= ljpf_pkg::OP_SQX;
      end else begin
         state_ff <= state_in;
         av_rd_ff <= vld_ff[ra];
         if (csr_we) begin
            case (csr_addr)
               ljpf_pkg::CSR_BOX_LENGTH: box_ff <= csr_wdata[PW-1:0];
               ljpf_pkg::CSR_CUTOFF_SQ:  cut_ff <= csr_wdata;
               default: cut_ff <= cut_ff;
            endcase
         end
         if (acc_we) vld_ff[wa] <= 1'b1;
         if (accept) begin
            count_ff <= count_nx;
            if (!load_we) dropped_ff <= 1'b1;
            if (req_data.last) begin
               n_ff   <= count_nx;
               vld_ff <= '0;
               i_ff   <= '0;
               j_ff   <= IW'(1);
               k_ff   <= '0;
            end
         end
         case (state_ff)
            ljpf_pkg::ST_ROW_LD:  j_ff <= i_ff + 1'b1;
            ljpf_pkg::ST_PAIR_LD: op_ff <= ljpf_pkg::OP_SQX;
            ljpf_pkg::ST_USE:     op_ff <= ljpf_pkg::op_type'(op_ff + 4'd1);
            ljpf_pkg::ST_CMP:     op_ff <= near ? ljpf_pkg::OP_CXL : ljpf_pkg::OP_S2;
            ljpf_pkg::ST_FAC:     op_ff <= ljpf_pkg::OP_CXL;
            ljpf_pkg::ST_NEXT:    j_ff <= j_ff + 1'b1;
            ljpf_pkg::ST_ROW_END: i_ff <= i_ff + 1'b1;
            ljpf_pkg::ST_OUT_EM: begin
               k_ff <= k_ff + 1'b1;
               if (state_in == ljpf_pkg::ST_IDLE) begin
                  count_ff   <= '0;
                  dropped_ff <= 1'b0;
               end
            end
            default: op_ff <= op_ff;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ljpf_pkg::ST_MUL) mul_p_ff <= mul_a * mul_b;
      if (div_done) s_ff <= div_q;
      case (state_ff)
         ljpf_pkg::ST_ROW_LD: begin
            pi_ff[0] <= sx_rd_ff;
            pi_ff[1] <= sy_rd_ff;
            pi_ff[2] <= sz_rd_ff;
            ai_ff[0] <= av_rd_ff ? ax_rd_ff : '0;
            ai_ff[1] <= av_rd_ff ? ay_rd_ff : '0;
            ai_ff[2] <= av_rd_ff ? az_rd_ff : '0;
         end
         ljpf_pkg::ST_PAIR_LD: begin
            aj_ff[0] <= av_rd_ff ? ax_rd_ff : '0;
            aj_ff[1] <= av_rd_ff ? ay_rd_ff : '0;
            aj_ff[2] <= av_rd_ff ? az_rd_ff : '0;
            for (int a = 0; a < 3; a++) begin
               dn_ff[a] <= d_w[a][ljpf_pkg::DEL_W-1];
               dm_ff[a] <= ljpf_pkg::DMAG_W'(d_w[a][ljpf_pkg::DEL_W-1] ? -d_w[a] : d_w[a]);
            end
         end
         ljpf_pkg::ST_USE: begin
            case (op_ff)
               ljpf_pkg::OP_SQX: r2_ff <= mul_p_ff[ljpf_pkg::R2_W-1:0];
               ljpf_pkg::OP_SQY,
               ljpf_pkg::OP_SQZ: r2_ff <= r2_ff + mul_p_ff[ljpf_pkg::R2_W-1:0];
               ljpf_pkg::OP_S2:  s2_ff <= mul_p_ff[47:22];
               ljpf_pkg::OP_S3:  s3_ff <= mul_p_ff[49:22];
               ljpf_pkg::OP_S4:  s4_ff <= mul_p_ff[51:22];
               ljpf_pkg::OP_S7:  s7_ff <= mul_p_ff[57:22];
               ljpf_pkg::OP_CXH: c_ff[0] <= ljpf_pkg::contrib(full, fneg_ff ^ dn_ff[0]);
               ljpf_pkg::OP_CYH: c_ff[1] <= ljpf_pkg::contrib(full, fneg_ff ^ dn_ff[1]);
               ljpf_pkg::OP_CZH: c_ff[2] <= ljpf_pkg::contrib(full, fneg_ff ^ dn_ff[2]);
               default:          lo_ff <= mul_p_ff[ljpf_pkg::LO_W-1:0];
            endcase
         end
         ljpf_pkg::ST_CMP: begin
            // pair too close for the divider: saturated positive factor
            fmag_ff <= ljpf_pkg::FACTOR_CAP;
            fneg_ff <= 1'b0;
         end
         ljpf_pkg::ST_FAC: begin
            fmag_ff <= fmag_in;
            fneg_ff <= fneg_in;
         end
         ljpf_pkg::ST_UPD: begin
            for (int a = 0; a < 3; a++) begin
               ai_ff[a] <= ljpf_pkg::sat32({ai_ff[a][FW-1], ai_ff[a]} + {c_ff[a][FW-1], c_ff[a]});
            end
         end
         default: lo_ff <= lo_ff;
      endcase
   end

   always_comb begin
      rsp_data.particle  = ljpf_pkg::PID_W'(k_ff);
      rsp_data.force_x   = av_rd_ff ? ax_rd_ff : '0;
      rsp_data.force_y   = av_rd_ff ? ay_rd_ff : '0;
      rsp_data.force_z   = av_rd_ff ? az_rd_ff : '0;
      rsp_data.overflow  = dropped_ff;
      rsp_data.final_res = CW'(k_ff) + 1'b1 == n_ff;
   end
endmodule

@@ src/ljpf_checker.sv @@
// Port-level checks for the pair force accumulator, bound to the top level.
// Depends on ljpf_pkg and lj_pair_force_accumulator.
module ljpf_port_checks (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ljpf_pkg::req_type req_data,
   input logic              rsp_valid,
   input ljpf_pkg::rsp_type rsp_data
);
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a computation");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_res |=> !busy && !rsp_valid)
      else $error("block not idle after the final result");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_data.last |=> !busy)
      else $error("plain load left the block busy");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back results");

   a_rsp_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.final_res |=> ##1
         (rsp_valid && rsp_data.particle == 6'($past(rsp_data.particle, 2) + 6'd1)))
      else $error("results out of order");
endmodule

bind lj_pair_force_accumulator ljpf_port_checks u_ljpf_checker (.*);
